FILE: sv/jha_pkg.sv
package jha_pkg;

  // Sizes
  localparam int BIN_W      = 8;
  localparam int BINS       = 1 << BIN_W;
  localparam int JADDR_W    = 2 * BIN_W;
  localparam int COUNT_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SCALE_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = SAMPLE_W + SCALE_W;
  localparam int BINFULL_W  = PROD_W - FRAC_W;
  localparam int BINCFG_W   = 9;
  localparam int CFG_IW     = 3;
  localparam int QDEPTH     = 4;
  localparam int Q_AW       = 2;
  localparam int Q_CW       = 3;

  // Round-to-nearest offset for the Q24.16 product
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Reset values of the configuration registers
  localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(65536);
  localparam logic [BINCFG_W-1:0] BINS_RESET  = BINCFG_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SCALE_S  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SCALE_T  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BINS_S   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BINS_T   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_REV_MASK = 3'd4;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_MASKED  = 3'd1,
    ST_RANGE_S = 3'd2,
    ST_RANGE_T = 3'd3,
    ST_DONE    = 3'd4
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [SAMPLE_W-1:0] sample_s;
    logic [SAMPLE_W-1:0] sample_t;
    logic                inside_mask;
    logic [BIN_W-1:0]    read_bin_s;
    logic [BIN_W-1:0]    read_bin_t;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] joint_count;
    logic [COUNT_W-1:0] count_s;
    logic [COUNT_W-1:0] count_t;
  } out_item_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale_s;
    logic [SCALE_W-1:0]  scale_t;
    logic [BINCFG_W-1:0] bins_s;
    logic [BINCFG_W-1:0] bins_t;
    logic                reverse_mask;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [BIN_W-1:0] bin_s;
    logic [BIN_W-1:0] bin_t;
  } cmd_t;

  // Queue fill status seen by the front
  typedef struct packed {
    logic            valid;
    logic [Q_CW-1:0] count;
  } q_sts_t;

endpackage

FILE: sv/jha_queue.sv
module jha_queue
  import jha_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output q_sts_t sts
);

  cmd_t            mem_r [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign sts.valid = (count_r != '0);
  assign sts.count = count_r;

endmodule

FILE: sv/jha_front.sv
module jha_front
  import jha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_take,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  input  q_sts_t   q_sts,
  input  logic     init,
  output logic     full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  // Stage 1: accepted item
  logic     v1_r;
  in_item_t item1_r;

  // Stage 2: bins from the products
  logic                 v2_r;
  op_t                  op2_r;
  logic                 skip2_r;
  logic [BINFULL_W-1:0] bin_s2_r, bin_t2_r;
  logic [BIN_W-1:0]     rbin_s2_r, rbin_t2_r;

  logic [PROD_W-1:0]   prod_s, prod_t;
  logic [BINCFG_W-1:0] lim_s, lim_t;
  logic [Q_CW-1:0]     occ;

  // Items in flight count against queue space
  always_comb begin
    occ  = q_sts.count + Q_CW'(v1_r) + Q_CW'(v2_r);
    full = init || (occ >= Q_CW'(QDEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item1_r <= in_item;
    end
  end

  // Binning: (sample * scale + half) >> 16
  always_comb begin
    prod_s = PROD_W'(item1_r.sample_s) * PROD_W'(cfg.scale_s) + ROUND_HALF;
    prod_t = PROD_W'(item1_r.sample_t) * PROD_W'(cfg.scale_t) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      op2_r     <= item1_r.operation;
      skip2_r   <= (item1_r.inside_mask == cfg.reverse_mask);
      bin_s2_r  <= prod_s[PROD_W-1:FRAC_W];
      bin_t2_r  <= prod_t[PROD_W-1:FRAC_W];
      rbin_s2_r <= item1_r.read_bin_s;
      rbin_t2_r <= item1_r.read_bin_t;
    end
  end

  // Classification into a back-end command
  always_comb begin
    lim_s = (cfg.bins_s > BINCFG_W'(BINS)) ? BINCFG_W'(BINS) : cfg.bins_s;
    lim_t = (cfg.bins_t > BINCFG_W'(BINS)) ? BINCFG_W'(BINS) : cfg.bins_t;
    q_push       = v2_r;
    q_cmd.op     = op2_r;
    q_cmd.status = ST_DONE;
    q_cmd.bin_s  = rbin_s2_r;
    q_cmd.bin_t  = rbin_t2_r;
    case (op2_r)
      OP_ACC: begin
        q_cmd.bin_s = bin_s2_r[BIN_W-1:0];
        q_cmd.bin_t = bin_t2_r[BIN_W-1:0];
        if (skip2_r) begin
          q_cmd.status = ST_MASKED;
        end else if (bin_s2_r >= BINFULL_W'(lim_s)) begin
          q_cmd.status = ST_RANGE_S;
        end else if (bin_t2_r >= BINFULL_W'(lim_t)) begin
          q_cmd.status = ST_RANGE_T;
        end else begin
          q_cmd.status = ST_COUNTED;
        end
      end
      default: q_cmd.status = ST_DONE;
    endcase
  end

endmodule

FILE: sv/jha_back.sv
module jha_back
  import jha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_sts_t    q_sts,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      init
);

  typedef enum logic [3:0] {
    BS_INIT  = 4'b0001,
    BS_IDLE  = 4'b0010,
    BS_LOOK  = 4'b0100,
    BS_CLEAR = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [COUNT_W-1:0] joint_mem [BINS*BINS];
  logic [COUNT_W-1:0] marg_s_mem [BINS];
  logic [COUNT_W-1:0] marg_t_mem [BINS];

  logic [COUNT_W-1:0] rd_j_r, rd_s_r, rd_t_r;
  logic [JADDR_W-1:0] clr_idx_r, clr_idx_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               out_free, rd_en, wr_en, sweep, last_idx;
  logic [JADDR_W-1:0] wr_addr_j;
  logic [BIN_W-1:0]   wr_addr_s, wr_addr_t;
  logic [COUNT_W-1:0] wr_j, wr_s, wr_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + COUNT_W'(1);
  endfunction

  assign out_free = !out_valid_r || out_pop;
  assign sweep    = (state_r == BS_INIT) || (state_r == BS_CLEAR);
  assign last_idx = (clr_idx_r == '1);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    case (state_r)
      BS_INIT: begin
        wr_en       = 1'b1;
        clr_idx_nxt = clr_idx_r + JADDR_W'(1);
        if (last_idx) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_sts.valid) begin
          if ((head.op == OP_ACC && head.status == ST_COUNTED) ||
              head.op == OP_READ) begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            cmd_nxt   = head;
            state_nxt = BS_LOOK;
          end else if (head.op == OP_CLEAR) begin
            q_pop       = 1'b1;
            clr_idx_nxt = '0;
            state_nxt   = BS_CLEAR;
          end else if (out_free) begin
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: head.status, default: '0};
          end
        end
      end
      BS_LOOK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = BS_IDLE;
          if (cmd_r.op == OP_READ) begin
            out_nxt = '{status: ST_DONE, joint_count: rd_j_r,
                        count_s: rd_s_r, count_t: rd_t_r};
          end else begin
            wr_en   = 1'b1;
            out_nxt = '{status: ST_COUNTED, default: '0};
          end
        end
      end
      BS_CLEAR: begin
        wr_en = 1'b1;
        if (!last_idx) begin
          clr_idx_nxt = clr_idx_r + JADDR_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_DONE, default: '0};
          state_nxt     = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_INIT;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  // Write port: zero sweep or saturating increment
  always_comb begin
    if (sweep) begin
      wr_addr_j = clr_idx_r;
      wr_addr_s = clr_idx_r[BIN_W-1:0];
      wr_addr_t = clr_idx_r[BIN_W-1:0];
      wr_j      = '0;
      wr_s      = '0;
      wr_t      = '0;
    end else begin
      wr_addr_j = {cmd_r.bin_s, cmd_r.bin_t};
      wr_addr_s = cmd_r.bin_s;
      wr_addr_t = cmd_r.bin_t;
      wr_j      = sat_inc(rd_j_r);
      wr_s      = sat_inc(rd_s_r);
      wr_t      = sat_inc(rd_t_r);
    end
  end

  // Histogram memories, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      joint_mem[wr_addr_j]  <= wr_j;
      marg_s_mem[wr_addr_s] <= wr_s;
      marg_t_mem[wr_addr_t] <= wr_t;
    end
    if (rd_en) begin
      rd_j_r <= joint_mem[{head.bin_s, head.bin_t}];
      rd_s_r <= marg_s_mem[head.bin_s];
      rd_t_r <= marg_t_mem[head.bin_t];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign init      = (state_r == BS_INIT);

endmodule

FILE: sv/joint_histogram_accumulator.sv
// Flow: an accepted item passes the front end's item and bin registers and the command
// queue. A skipped pair's result is registered as it is popped; reads and counted
// pairs first read the memories (read-modify-write for counted pairs), then register the
// result, and are finished before the next command is taken. A clear sweeps all 65536
// joint bins. Reset: synchronous, active low; afterwards a sweep zeroes the histograms
// while in_full stays high. Configuration writes are taken at any time.
module joint_histogram_accumulator
  import jha_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  in_item_t            in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [SCALE_W-1:0]  cfg_data
);

  cfg_t   cfg_r;
  logic   in_take, init, out_valid;
  logic   q_push, q_pop;
  cmd_t   q_cmd, q_head;
  q_sts_t q_sts;

  assign cfg_ready = 1'b1;
  assign in_take   = in_push && !in_full;
  assign out_empty = !out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_s      <= SCALE_RESET;
      cfg_r.scale_t      <= SCALE_RESET;
      cfg_r.bins_s       <= BINS_RESET;
      cfg_r.bins_t       <= BINS_RESET;
      cfg_r.reverse_mask <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE_S:  cfg_r.scale_s      <= cfg_data;
        CFG_SCALE_T:  cfg_r.scale_t      <= cfg_data;
        CFG_BINS_S:   cfg_r.bins_s       <= cfg_data[BINCFG_W-1:0];
        CFG_BINS_T:   cfg_r.bins_t       <= cfg_data[BINCFG_W-1:0];
        CFG_REV_MASK: cfg_r.reverse_mask <= cfg_data[0];
        default: ;
      endcase
    end
  end

  jha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_item (in_item),
    .cfg     (cfg_r),
    .q_sts   (q_sts),
    .init    (init),
    .full    (in_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  jha_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .sts      (q_sts)
  );

  jha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_sts     (q_sts),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .init      (init)
  );

`ifndef SYNTHESIS
  // No item may enter during the post-reset sweep
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    init |-> in_full)
    else $error("item accepted during histogram init sweep");

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_sts.count <= Q_CW'(QDEPTH))
    else $error("command queue overflow");

  // Results with a status other than done carry zero counts
  a_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.status != ST_DONE) |->
      (out_item.joint_count == '0 && out_item.count_s == '0 &&
       out_item.count_t == '0))
    else $error("accumulate result with nonzero counts");
`endif

endmodule

FILE: sim/joint_histogram_accumulator_tb.sv
module joint_histogram_accumulator_tb;
  import jha_pkg::*;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 16;
  localparam int CYCLE_LIMIT     = 2_000_000;

  // Index with no register behind it; writes there must be ignored
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  in_item_t            in_item = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [SCALE_W-1:0]  cfg_data = '0;

  joint_histogram_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow histograms and register copy
  logic [COUNT_W-1:0] joint_hist [BINS*BINS];
  logic [COUNT_W-1:0] marg_hist_s [BINS];
  logic [COUNT_W-1:0] marg_hist_t [BINS];
  cfg_t               cur_cfg;
  logic [BIN_W-1:0]   last_hit_s = '0;
  logic [BIN_W-1:0]   last_hit_t = '0;

  out_item_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          push_quiet = 1'b0;
  bit          pop_quiet = 1'b0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic int eff_bins(logic [BINCFG_W-1:0] n);
    return (n > BINS) ? BINS : int'(n);
  endfunction

  function automatic void clear_histograms();
    foreach (joint_hist[i]) joint_hist[i] = '0;
    foreach (marg_hist_s[i]) marg_hist_s[i] = '0;
    foreach (marg_hist_t[i]) marg_hist_t[i] = '0;
  endfunction

  // Bin, count and read back one item against the shadow histograms
  function automatic out_item_t histogram_step(in_item_t it);
    out_item_t        r;
    logic [63:0]      bin_s;
    logic [63:0]      bin_t;
    logic [JADDR_W-1:0] ja;
    r = '0;
    r.status = ST_DONE;
    case (it.operation)
      OP_ACC: begin
        if (it.inside_mask == cur_cfg.reverse_mask) begin
          r.status = ST_MASKED;
        end else begin
          // Q24.16 product, round half up
          bin_s = (64'(it.sample_s) * 64'(cur_cfg.scale_s) + (64'd1 << (FRAC_W - 1)))
                  >> FRAC_W;
          bin_t = (64'(it.sample_t) * 64'(cur_cfg.scale_t) + (64'd1 << (FRAC_W - 1)))
                  >> FRAC_W;
          if (bin_s >= 64'(eff_bins(cur_cfg.bins_s))) begin
            r.status = ST_RANGE_S;
          end else if (bin_t >= 64'(eff_bins(cur_cfg.bins_t))) begin
            r.status = ST_RANGE_T;
          end else begin
            ja = {bin_s[BIN_W-1:0], bin_t[BIN_W-1:0]};
            if (marg_hist_s[bin_s[BIN_W-1:0]] != '1)
              marg_hist_s[bin_s[BIN_W-1:0]]++;
            if (marg_hist_t[bin_t[BIN_W-1:0]] != '1)
              marg_hist_t[bin_t[BIN_W-1:0]]++;
            if (joint_hist[ja] != '1)
              joint_hist[ja]++;
            last_hit_s = bin_s[BIN_W-1:0];
            last_hit_t = bin_t[BIN_W-1:0];
            r.status = ST_COUNTED;
          end
        end
      end
      OP_READ: begin
        r.count_s = marg_hist_s[it.read_bin_s];
        r.count_t = marg_hist_t[it.read_bin_t];
        r.joint_count = joint_hist[{it.read_bin_s, it.read_bin_t}];
      end
      OP_CLEAR: clear_histograms();
      default: ;
    endcase
    return r;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SCALE_W-1:0] scale, int eff);
    int unsigned lim;
    if (scale == 0 || $urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
    lim = (eff * 65536) / scale;
    if (lim > 65535) lim = 65535;
    return SAMPLE_W'($urandom_range(0, lim));
  endfunction

  function automatic logic [BIN_W-1:0] pick_read_bin(int eff, logic [BIN_W-1:0] hit);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return hit;
    if (r < 8) return BIN_W'($urandom_range(0, (eff > 0) ? eff - 1 : 0));
    return BIN_W'($urandom);
  endfunction

  // Random item: unused fields random too, so every bit toggles
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    it.sample_s    = SAMPLE_W'($urandom);
    it.sample_t    = SAMPLE_W'($urandom);
    it.inside_mask = 1'($urandom);
    it.read_bin_s  = BIN_W'($urandom);
    it.read_bin_t  = BIN_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 62) begin
      it.operation = OP_ACC;
      it.sample_s  = pick_sample(cur_cfg.scale_s, eff_bins(cur_cfg.bins_s));
      it.sample_t  = pick_sample(cur_cfg.scale_t, eff_bins(cur_cfg.bins_t));
      // favor pairs that pass the mask
      if ($urandom_range(0, 4) != 0) it.inside_mask = ~cur_cfg.reverse_mask;
    end else if (r < 92) begin
      it.operation  = OP_READ;
      it.read_bin_s = pick_read_bin(eff_bins(cur_cfg.bins_s), last_hit_s);
      it.read_bin_t = pick_read_bin(eff_bins(cur_cfg.bins_t), last_hit_t);
    end else begin
      it.operation = OP_NONE;
    end
    return it;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    c.scale_s      = SCALE_RESET;
    c.scale_t      = SCALE_RESET;
    c.bins_s       = BINS_RESET;
    c.bins_t       = BINS_RESET;
    c.reverse_mask = 1'b0;
    case (p)
      1: begin
        c.scale_s      = '1;
        c.scale_t      = 24'd1;
        c.reverse_mask = 1'b1;
      end
      2: begin
        c.scale_s = '0;
        c.scale_t = 24'd4096;
        c.bins_s  = 9'd1;
        c.bins_t  = 9'd16;
      end
      3: begin
        c.scale_s      = 24'd20000;
        c.scale_t      = 24'd300000;
        c.bins_s       = 9'd511;
        c.bins_t       = 9'd0;
        c.reverse_mask = 1'b1;
      end
      4, 5: begin
        c.scale_s      = SCALE_W'($urandom_range(256, 1 << 20));
        c.scale_t      = SCALE_W'($urandom_range(256, 1 << 20));
        c.bins_s       = BINCFG_W'($urandom_range(1, 256));
        c.bins_t       = BINCFG_W'($urandom_range(1, 256));
        c.reverse_mask = 1'($urandom);
      end
      6: begin
        c.scale_s = 24'd8192;
        c.scale_t = 24'd8192;
        c.bins_s  = 9'd8;
        c.bins_t  = 9'd8;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_item_t mk_acc(int s, int t, bit m);
    in_item_t it;
    it = '0;
    it.operation   = OP_ACC;
    it.sample_s    = SAMPLE_W'(s);
    it.sample_t    = SAMPLE_W'(t);
    it.inside_mask = m;
    return it;
  endfunction

  function automatic in_item_t mk_read(int s, int t);
    in_item_t it;
    it = '0;
    it.operation  = OP_READ;
    it.read_bin_s = BIN_W'(s);
    it.read_bin_t = BIN_W'(t);
    return it;
  endfunction

  function automatic out_item_t mk_out(status_t st, int unsigned j, int unsigned s,
                                       int unsigned t);
    out_item_t r;
    r.status      = st;
    r.joint_count = j;
    r.count_s     = s;
    r.count_t     = t;
    return r;
  endfunction

  // Send one item; keep push high across back-to-back items
  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = idle_len(push_quiet);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    forever begin
      @(posedge clk);
      if (in_full === 1'b0) break;
    end
    predicted = histogram_step(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stop sending until every result is back and the pipe has gone quiet
  task automatic settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers back to back, plus one write to an unused index
  task automatic load_settings(input cfg_t c);
    logic [CFG_IW-1:0]  idx [6];
    logic [SCALE_W-1:0] val [6];
    idx = '{CFG_SCALE_S, CFG_SCALE_T, CFG_BINS_S, CFG_BINS_T, CFG_REV_MASK, CFG_UNUSED};
    val[0] = c.scale_s;
    val[1] = c.scale_t;
    val[2] = {15'($urandom), c.bins_s};
    val[3] = {15'($urandom), c.bins_t};
    val[4] = {23'($urandom), c.reverse_mask};
    val[5] = SCALE_W'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      forever begin
        @(posedge clk);
        if (cfg_ready === 1'b1) break;
      end
      case (idx[i])
        CFG_SCALE_S:  cur_cfg.scale_s = val[i];
        CFG_SCALE_T:  cur_cfg.scale_t = val[i];
        CFG_BINS_S:   cur_cfg.bins_s = val[i][BINCFG_W-1:0];
        CFG_BINS_T:   cur_cfg.bins_t = val[i][BINCFG_W-1:0];
        CFG_REV_MASK: cur_cfg.reverse_mask = val[i][0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls on pop
  int unsigned pop_hold = 0;
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      pop_hold = idle_len(pop_quiet);
    end
  end

  // Compare each popped item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop === 1'b1 && out_empty === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %p", out_item);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.joint_count !== want.joint_count) begin
          $error("joint_count: expected %0d, got %0d", want.joint_count,
                 out_item.joint_count);
          error_count++;
        end
        if (out_item.count_s !== want.count_s) begin
          $error("count_s: expected %0d, got %0d", want.count_s, out_item.count_s);
          error_count++;
        end
        if (out_item.count_t !== want.count_t) begin
          $error("count_t: expected %0d, got %0d", want.count_t, out_item.count_t);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t none_item;

    cur_cfg.scale_s      = SCALE_RESET;
    cur_cfg.scale_t      = SCALE_RESET;
    cur_cfg.bins_s       = BINS_RESET;
    cur_cfg.bins_t       = BINS_RESET;
    cur_cfg.reverse_mask = 1'b0;
    clear_histograms();

    none_item = '1;
    none_item.operation = OP_NONE;

    // Directed rows, default settings: bin equals sample
    dir_rows.push_back('{mk_read(0, 0), 1'b1, mk_out(ST_DONE, 0, 0, 0)});
    dir_rows.push_back('{mk_read(255, 255), 1'b1, mk_out(ST_DONE, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(0, 0, 1), 1'b1, mk_out(ST_COUNTED, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(0, 0, 0), 1'b1, mk_out(ST_MASKED, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(255, 255, 1), 1'b1, mk_out(ST_COUNTED, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(256, 0, 1), 1'b1, mk_out(ST_RANGE_S, 0, 0, 0)});
    // both out of range: first one wins
    dir_rows.push_back('{mk_acc(65535, 65535, 1), 1'b1, mk_out(ST_RANGE_S, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(0, 256, 1), 1'b1, mk_out(ST_RANGE_T, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(3, 65535, 1), 1'b1, mk_out(ST_RANGE_T, 0, 0, 0)});
    // mask is tested before range
    dir_rows.push_back('{mk_acc(65535, 0, 0), 1'b1, mk_out(ST_MASKED, 0, 0, 0)});
    dir_rows.push_back('{mk_read(0, 0), 1'b1, mk_out(ST_DONE, 1, 1, 1)});
    dir_rows.push_back('{mk_read(255, 255), 1'b1, mk_out(ST_DONE, 1, 1, 1)});
    dir_rows.push_back('{mk_read(0, 255), 1'b1, mk_out(ST_DONE, 0, 1, 1)});
    dir_rows.push_back('{none_item, 1'b1, mk_out(ST_DONE, 0, 0, 0)});
    dir_rows.push_back('{mk_acc(255, 0, 1), 1'b1, mk_out(ST_COUNTED, 0, 0, 0)});
    dir_rows.push_back('{mk_read(255, 0), 1'b0, '0});
    dir_rows.push_back('{mk_acc(127, 128, 1), 1'b0, '0});
    dir_rows.push_back('{mk_read(127, 128), 1'b0, '0});
    dir_rows.push_back('{in_item_t'({OP_CLEAR, 49'h0}), 1'b1, mk_out(ST_DONE, 0, 0, 0)});
    dir_rows.push_back('{mk_read(255, 255), 1'b1, mk_out(ST_DONE, 0, 0, 0)});
    dir_rows.push_back('{mk_read(127, 128), 1'b0, '0});

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_settings(phase_settings(p));
      push_quiet = ($urandom_range(0, 3) == 0);
      pop_quiet  = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
      // start some phases from empty histograms
      if (p == 2 || p == 6) send(in_item_t'({OP_CLEAR, 49'h0}), 1'b0, '0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send(random_item(), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
